FILE: hw/rtl/lrp_pkg.sv
package lrp_pkg;

  // Field widths fixed by the item format
  localparam int RANK_W      = 4;
  localparam int VALUE_W     = 4;
  localparam int RANGE_W     = 5;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 5'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;   // item accepted: load rank, clear scan position
    logic step;    // scanning: advance one slot unless finished
    logic load;    // move result to output register, update taken map
  } lrp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_hit;  // current slot is the requested free value
    logic scan_end;  // scan ran past the effective range
  } lrp_stat_t;

endpackage

FILE: hw/rtl/lrp_ctrl.sv
module lrp_ctrl import lrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  lrp_stat_t stat,
  output lrp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.start = 1'b0;
    cmd.step  = 1'b0;
    cmd.load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_hit || stat.scan_end) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the item is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled output item");

  // Load always yields a valid output and frees the input side
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r && (state_r == S_IDLE))
    else $error("load did not present a result");

  // Result state is only reached through a finished scan
  a_result_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) && ($past(state_r) != S_RESULT) |->
      $past(state_r) == S_SCAN && ($past(stat.scan_hit) || $past(stat.scan_end)))
    else $error("result state entered without scan completion");

endmodule

FILE: hw/rtl/lrp_dpath.sv
module lrp_dpath import lrp_pkg::*; #(
  parameter int MAX_RANGE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [RANGE_W-1:0] cfg_data,
  input  logic [RANK_W-1:0]  in_rank,
  input  logic               in_last_pick,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_invalid,
  input  lrp_cmd_t           cmd,
  output lrp_stat_t          stat
);

  localparam int SW = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;
  localparam int CW = $clog2(MAX_RANGE + 1);
  localparam int RW = (CW > RANGE_W) ? CW : RANGE_W;

  logic [RANGE_W-1:0]   range_size_r;
  logic [MAX_RANGE-1:0] map_r;
  logic [CW-1:0]        slot_r;
  logic [RANK_W-1:0]    rem_r;
  logic                 last_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic                 out_invalid_r;

  logic [RW-1:0]        eff_range;
  logic [SW-1:0]        slot_idx;
  logic                 in_range;
  logic                 slot_free;

  // Effective range, saturated at MAX_RANGE
  assign eff_range = (RW'(range_size_r) > RW'(MAX_RANGE)) ? RW'(MAX_RANGE)
                                                          : RW'(range_size_r);

  // Slot under test
  assign slot_idx  = slot_r[SW-1:0];
  assign in_range  = RW'(slot_r) < eff_range;
  assign slot_free = !map_r[slot_idx];

  assign stat.scan_end = !in_range;
  assign stat.scan_hit = in_range && slot_free && (rem_r == '0);

  assign out_value   = out_value_r;
  assign out_invalid = out_invalid_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_size_r <= RANGE_RESET;
    end else if (cfg_valid) begin
      range_size_r <= cfg_data;
    end
  end

  // Taken map: set on a good pick, cleared after the last digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else if (cmd.load && !stat.scan_end) begin
      if (last_r) begin
        map_r <= '0;
      end else begin
        map_r <= map_r | (MAX_RANGE'(1) << slot_idx);
      end
    end
  end

  // Scan position and remaining rank; position freezes on a hit or at the end
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      slot_r <= '0;
      rem_r  <= in_rank;
      last_r <= in_last_pick;
    end else if (cmd.step && !stat.scan_hit && !stat.scan_end) begin
      slot_r <= slot_r + CW'(1);
      if (slot_free) begin
        rem_r <= rem_r - RANK_W'(1);
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value_r   <= stat.scan_end ? '0 : VALUE_W'(slot_r);
      out_invalid_r <= stat.scan_end;
    end
  end

  // A good pick that is not the last leaves its slot marked
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !stat.scan_end && !last_r) |=> map_r[$past(slot_idx)])
    else $error("picked slot not marked as taken");

  // The last good pick leaves the map empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !stat.scan_end && last_r) |=> (map_r == '0))
    else $error("taken map not cleared after last digit");

endmodule

FILE: hw/rtl/lehmer_rank_to_permutation.sv
// Lehmer code digit decoder.
// Input channel (in_valid / in_stall): one item per digit, in_rank selects the
// rank-th value, from zero, among 0..range-1 not yet taken in the sequence;
// in_last_pick ends the sequence and clears the taken map after a good pick.
// Output channel (out_valid / out_stall): one item per input, out_value is
// the chosen value (0 when invalid) and out_invalid flags a rank not below
// the count of free values; an invalid digit changes nothing.
// Config channel (cfg_valid / cfg_ready): writes range_size, saturated at
// MAX_RANGE; cfg_ready is always high. Write only while the block is idle.
// Timing: a slot scanner tests one slot of the taken map per cycle. The scan
// stops at the requested free slot, or past the effective range for an
// invalid item; the result state then loads the output register and raises
// out_valid. The controller then returns to idle before it accepts the next
// item, so a new item is not taken before the last one has been loaded.
// in_stall is high from acceptance until the result enters the output
// register; if the receiver stalls with a result still waiting, the finished
// item waits in the controller and the input stays stalled.
// Reset (synchronous, rst_n low): taken map empty, range_size 16, no output.
module lehmer_rank_to_permutation import lrp_pkg::*; #(
  parameter int MAX_RANGE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RANGE_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RANK_W-1:0]  in_rank,
  input  logic               in_last_pick,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_invalid
);

  lrp_cmd_t  cmd;
  lrp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  lrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Taken map, slot scanner and output register
  lrp_dpath #(
    .MAX_RANGE (MAX_RANGE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_rank      (in_rank),
    .in_last_pick (in_last_pick),
    .out_value    (out_value),
    .out_invalid  (out_invalid),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
